[rtl/vna_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the vertex normal accumulator.
// No dependencies; used by vna_sat_add and vertex_normal_accumulator.
package vna_pkg;

   // Defaults for the top-level parameters
   localparam int VERTEX_COUNT_DEF = 1024;
   localparam int COORD_BITS_DEF   = 16;
   localparam int ACCUM_BITS_DEF   = 48;

   // Command codes
   localparam logic [1:0] CMD_LOAD = 2'd0;
   localparam logic [1:0] CMD_TRI  = 2'd1;
   localparam logic [1:0] CMD_READ = 2'd2;

   typedef struct packed {
      logic [1:0]         command;
      logic [9:0]         first_index;
      logic [9:0]         second_index;
      logic [9:0]         third_index;
      logic signed [15:0] coord_x;
      logic signed [15:0] coord_y;
      logic signed [15:0] coord_z;
   } req_type;

   typedef struct packed {
      logic signed [47:0] normal_x;
      logic signed [47:0] normal_y;
      logic signed [47:0] normal_z;
   } rsp_type;

endpackage

[rtl/vertex_normal_accumulator.sv]
`timescale 1ns / 1ps
// Area-weighted vertex normal accumulator: top level.
// Depends on vna_pkg and vna_sat_add.
//
// Requests arrive on req_ (valid/stall, payload vna_pkg::req_type); results
// leave on rsp_ (valid/stall, payload vna_pkg::rsp_type).
// A load transfer writes one vertex.
// A triangle transfer does three vertex reads through the single
// vertex memory port, three component multiplies with one pair of
// multipliers (multiply, then subtract), then a read-modify-write of each
// corner's normal through the single normal memory port.
// Corners are updated one after the other, so repeated corners need no
// forwarding.
// A read transfer reads the normal memory, then loads the result into an output
// register (skipping the read when its index is out of range); the result is
// held there until the receiver takes it. A later read that finds the register
// still full waits for it inside the block, holding req_stall high meanwhile.
// Indices at or above VERTEX_COUNT make loads and triangles no-ops and reads
// return zero.
// After reset the normal memory is swept to zero, one entry a cycle, over all
// VERTEX_COUNT entries; req_stall stays high throughout.
module vertex_normal_accumulator #(
   parameter int VERTEX_COUNT = vna_pkg::VERTEX_COUNT_DEF,
   parameter int COORD_BITS   = vna_pkg::COORD_BITS_DEF,
   parameter int ACCUM_BITS   = vna_pkg::ACCUM_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  vna_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output vna_pkg::rsp_type rsp_data
);

   localparam int AW = $clog2(VERTEX_COUNT);
   localparam int CB = COORD_BITS;
   localparam int DB = CB + 1;
   localparam int PB = 2 * DB;
   localparam int XB = PB + 1;
   localparam int NW = 3 * ACCUM_BITS;
   localparam int VW = 3 * CB;

   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_VA    = 4'd2;
   localparam logic [3:0] S_VB    = 4'd3;
   localparam logic [3:0] S_VC    = 4'd4;
   localparam logic [3:0] S_DIFF  = 4'd5;
   localparam logic [3:0] S_MUL   = 4'd6;
   localparam logic [3:0] S_SUB   = 4'd7;
   localparam logic [3:0] S_NRD   = 4'd8;
   localparam logic [3:0] S_NWR   = 4'd9;
   localparam logic [3:0] S_RRD   = 4'd10;
   localparam logic [3:0] S_ROUT  = 4'd11;

   logic [3:0]    state_ff, state_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic [1:0]    step_ff, step_in;
   logic [AW-1:0] idx_ff[3];
   logic [AW-1:0] idx_in[3];
   logic          zero_ff, zero_in;

   // Memories and their registered read data
   logic [VW-1:0] vmem[VERTEX_COUNT];
   logic [NW-1:0] nmem[VERTEX_COUNT];
   logic [VW-1:0] vq_ff;
   logic [NW-1:0] nq_ff;
   logic          vwe, vre, nwe, nre;
   logic [AW-1:0] vaddr, naddr;
   logic [VW-1:0] vwdata;
   logic [NW-1:0] nwdata;

   // Arithmetic registers
   logic signed [CB-1:0] va_ff[3];
   logic signed [CB-1:0] vb_ff[3];
   logic signed [DB-1:0] u_ff[3];
   logic signed [DB-1:0] w_ff[3];
   logic signed [PB-1:0] p0_ff, p1_ff;
   logic signed [XB-1:0] n_ff[3];
   logic signed [CB-1:0] vq_c[3];
   logic signed [DB-1:0] m0a, m0b, m1a, m1b;
   logic signed [ACCUM_BITS-1:0] acc_c[3];
   logic signed [ACCUM_BITS-1:0] sum_c[3];

   logic          rsp_valid_ff, rsp_valid_in;
   vna_pkg::rsp_type rsp_ff, rsp_in;

   logic          req_xfer;
   logic          rsp_xfer;
   logic          a_ok, b_ok, c_ok;

   assign req_stall = (state_ff != S_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign rsp_xfer  = rsp_valid_ff && !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign a_ok = (32'(req_data.first_index) < VERTEX_COUNT);
   assign b_ok = (32'(req_data.second_index) < VERTEX_COUNT);
   assign c_ok = (32'(req_data.third_index) < VERTEX_COUNT);

   // Unpack the vertex read word
   assign vq_c[0] = vq_ff[3*CB-1:2*CB];
   assign vq_c[1] = vq_ff[2*CB-1:CB];
   assign vq_c[2] = vq_ff[CB-1:0];

   assign acc_c[0] = nq_ff[3*ACCUM_BITS-1:2*ACCUM_BITS];
   assign acc_c[1] = nq_ff[2*ACCUM_BITS-1:ACCUM_BITS];
   assign acc_c[2] = nq_ff[ACCUM_BITS-1:0];

   for (genvar g = 0; g < 3; g++) begin : g_sat
      vna_sat_add #(
         .ACCUM_BITS (ACCUM_BITS),
         .CROSS_BITS (XB)
      ) u_sat (
         .acc (acc_c[g]),
         .inc (n_ff[g]),
         .sum (sum_c[g])
      );
   end

   // Operand selection for the component being multiplied
   always_comb begin
      case (step_ff)
         2'd0: begin
            m0a = u_ff[1]; m0b = w_ff[2]; m1a = u_ff[2]; m1b = w_ff[1];
         end
         2'd1: begin
            m0a = u_ff[2]; m0b = w_ff[0]; m1a = u_ff[0]; m1b = w_ff[2];
         end
         default: begin
            m0a = u_ff[0]; m0b = w_ff[1]; m1a = u_ff[1]; m1b = w_ff[0];
         end
      endcase
   end

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      step_in      = step_ff;
      idx_in       = idx_ff;
      zero_in      = zero_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_xfer;
      rsp_in       = rsp_ff;
      vwe          = 1'b0;
      vre          = 1'b0;
      nwe          = 1'b0;
      nre          = 1'b0;
      vaddr        = AW'(req_data.first_index);
      naddr        = idx_ff[step_ff];
      vwdata       = {CB'($unsigned(req_data.coord_x)), CB'($unsigned(req_data.coord_y)),
                      CB'($unsigned(req_data.coord_z))};
      nwdata       = {sum_c[0], sum_c[1], sum_c[2]};
      case (state_ff)
         S_CLEAR: begin
            nwe    = 1'b1;
            naddr  = clr_ff;
            nwdata = '0;
            clr_in = clr_ff + AW'(1);
            if (clr_ff == AW'(VERTEX_COUNT - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_xfer) begin
               idx_in[0] = AW'(req_data.first_index);
               idx_in[1] = AW'(req_data.second_index);
               idx_in[2] = AW'(req_data.third_index);
               step_in   = 2'd0;
               case (req_data.command)
                  vna_pkg::CMD_LOAD: begin
                     vwe = a_ok;
                  end
                  vna_pkg::CMD_TRI: begin
                     if (a_ok && b_ok && c_ok) begin
                        state_in = S_VA;
                     end
                  end
                  vna_pkg::CMD_READ: begin
                     zero_in  = !a_ok;
                     state_in = a_ok ? S_RRD : S_ROUT;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_VA: begin
            vre      = 1'b1;
            vaddr    = idx_ff[0];
            state_in = S_VB;
         end
         S_VB: begin
            vre      = 1'b1;
            vaddr    = idx_ff[1];
            state_in = S_VC;
         end
         S_VC: begin
            vre      = 1'b1;
            vaddr    = idx_ff[2];
            state_in = S_DIFF;
         end
         S_DIFF: begin
            state_in = S_MUL;
         end
         S_MUL: begin
            state_in = S_SUB;
         end
         S_SUB: begin
            if (step_ff == 2'd2) begin
               step_in  = 2'd0;
               state_in = S_NRD;
            end else begin
               step_in  = step_ff + 2'd1;
               state_in = S_MUL;
            end
         end
         S_NRD: begin
            nre      = 1'b1;
            state_in = S_NWR;
         end
         S_NWR: begin
            nwe = 1'b1;
            if (step_ff == 2'd2) begin
               step_in  = 2'd0;
               state_in = S_IDLE;
            end else begin
               step_in  = step_ff + 2'd1;
               state_in = S_NRD;
            end
         end
         S_RRD: begin
            nre      = 1'b1;
            naddr    = idx_ff[0];
            state_in = S_ROUT;
         end
         S_ROUT: begin
            if (!rsp_valid_ff || rsp_xfer) begin
               rsp_valid_in = 1'b1;
               if (zero_ff) begin
                  rsp_in = '0;
               end else begin
                  rsp_in.normal_x = 48'($unsigned(acc_c[0]));
                  rsp_in.normal_y = 48'($unsigned(acc_c[1]));
                  rsp_in.normal_z = 48'($unsigned(acc_c[2]));
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Vertex memory, one port
   always_ff @(posedge clock) begin
      if (vwe) begin
         vmem[vaddr] <= vwdata;
      end
      if (vre) begin
         vq_ff <= vmem[vaddr];
      end
   end

   // Normal memory, one port
   always_ff @(posedge clock) begin
      if (nwe) begin
         nmem[naddr] <= nwdata;
      end
      if (nre) begin
         nq_ff <= nmem[naddr];
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      if (state_ff == S_VB) begin
         va_ff <= vq_c;
      end
      if (state_ff == S_VC) begin
         vb_ff <= vq_c;
      end
      if (state_ff == S_DIFF) begin
         for (int k = 0; k < 3; k++) begin
            u_ff[k] <= DB'(vb_ff[k]) - DB'(va_ff[k]);
            w_ff[k] <= DB'(vq_c[k]) - DB'(va_ff[k]);
         end
      end
      if (state_ff == S_MUL) begin
         p0_ff <= m0a * m0b;
         p1_ff <= m1a * m1b;
      end
      if (state_ff == S_SUB) begin
         n_ff[step_ff] <= XB'(p0_ff) - XB'(p1_ff);
      end
      rsp_ff <= rsp_in;
      idx_ff <= idx_in;
      zero_ff <= zero_in;
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         step_ff      <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

[rtl/vna_sat_add.sv]
`timescale 1ns / 1ps
// Saturating add of one cross-product component into one accumulator.
// Depends on vna_pkg for its parameter defaults; instanced three times by vertex_normal_accumulator.
module vna_sat_add #(
   parameter int ACCUM_BITS = vna_pkg::ACCUM_BITS_DEF,
   parameter int CROSS_BITS = 2 * vna_pkg::COORD_BITS_DEF + 3
) (
   input  logic signed [ACCUM_BITS-1:0] acc,
   input  logic signed [CROSS_BITS-1:0] inc,
   output logic signed [ACCUM_BITS-1:0] sum
);

   localparam int SW = ((ACCUM_BITS > CROSS_BITS) ? ACCUM_BITS : CROSS_BITS) + 1;

   logic signed [SW-1:0] wide;
   logic signed [SW-1:0] hi;
   logic signed [SW-1:0] lo;

   // Exact sum at full width, then clamp to the accumulator range
   always_comb begin
      hi   = SW'($signed({1'b0, {(ACCUM_BITS-1){1'b1}}}));
      lo   = SW'($signed({1'b1, {(ACCUM_BITS-1){1'b0}}}));
      wide = SW'(acc) + SW'(inc);
      if (wide > hi) begin
         sum = hi[ACCUM_BITS-1:0];
      end else if (wide < lo) begin
         sum = lo[ACCUM_BITS-1:0];
      end else begin
         sum = wide[ACCUM_BITS-1:0];
      end
   end

endmodule
